FILE: rtl/core/tpsf_pkg.sv
// package: widths, register indexes, sequencer states, payloads and multiplier request
package tpsf_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegDirectMode   = 3'd0,
    RegLineToLine   = 3'd1,
    RegOpenThresh   = 3'd2,
    RegTimeStep     = 3'd3,
    RegResLineLine  = 3'd4,
    RegResLineGnd   = 3'd5,
    RegInvIndLL     = 3'd6,
    RegInvIndLG     = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StMask,
    StResMul,
    StDtMul,
    StIndMul,
    StNext,
    StDone
  } seq_state_e;

  localparam logic [1:0] PhA = 2'd0;
  localparam logic [1:0] PhB = 2'd1;
  localparam logic [1:0] PhC = 2'd2;

  typedef struct packed {
    logic               fault_enable;
    logic [2:0]         fault_command;
    logic signed [31:0] va_fault_in;
    logic signed [31:0] vb_fault_in;
    logic signed [31:0] vc_fault_in;
    logic signed [31:0] va_source;
    logic signed [31:0] vb_source;
    logic signed [31:0] vc_source;
  } fault_in_t;

  typedef struct packed {
    logic [2:0]         fault_mask;
    logic signed [31:0] va_out;
    logic signed [31:0] vb_out;
    logic signed [31:0] vc_out;
    logic signed [31:0] ia_out;
    logic signed [31:0] ib_out;
    logic signed [31:0] ic_out;
  } fault_out_t;

  // operand selection for the shared multiplier
  typedef struct packed {
    logic               start;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
  } mul_req_t;

endpackage

FILE: rtl/core/tpsf_if.sv
// valid/ready channel interface with a generic payload
interface tpsf_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/three_phase_short_fault_model_unit.sv
// three-phase short-circuit fault model, top level
// A request is taken in the idle state. Direct mode then does the mask update and the clear;
// integrating mode also runs, for each integrated phase or pair, R*i, dt*term and flux*(1/L)
// in turn on the one 32x32 multiplier in tpsf_mul. A new request is only taken once the
// sequencer is back in the idle state. The result sits in an output register, so a request is
// only held in the done state when the earlier result has still not been delivered.
module three_phase_short_fault_model_unit #(
  parameter int unsigned DATA_WIDTH = tpsf_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tpsf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpsf_pkg::CfgDataW-1:0] cfg_data_i,
  tpsf_if.sink                          in_if,
  tpsf_if.source                        out_if
);
  localparam int unsigned WordBits = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic signed [63:0] WordMax = 64'sd2 ** (WordBits - 1) - 64'sd1;
  localparam logic signed [63:0] WordMin = -WordMax - 64'sd1;

  function automatic logic signed [63:0] sat(input logic signed [63:0] x);
    logic signed [63:0] r;
    r = x;
    if (x > WordMax) r = WordMax;
    if (x < WordMin) r = WordMin;
    return r;
  endfunction

  // configuration
  logic        dmode_q, ll_q;
  logic [30:0] thr_q, dt_q, rll_q, rlg_q;
  logic [31:0] ill_q, ilg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmode_q <= 1'b0; ll_q <= 1'b0; thr_q <= '0; dt_q <= '0;
      rll_q <= '0; rlg_q <= '0; ill_q <= '0; ilg_q <= '0;
    end else if (cfg_we_i) begin
      case (tpsf_pkg::cfg_reg_e'(cfg_idx_i))
        tpsf_pkg::RegDirectMode:  dmode_q <= cfg_data_i[0];
        tpsf_pkg::RegLineToLine:  ll_q    <= cfg_data_i[0];
        tpsf_pkg::RegOpenThresh:  thr_q   <= cfg_data_i[30:0];
        tpsf_pkg::RegTimeStep:    dt_q    <= cfg_data_i[30:0];
        tpsf_pkg::RegResLineLine: rll_q   <= cfg_data_i[30:0];
        tpsf_pkg::RegResLineGnd:  rlg_q   <= cfg_data_i[30:0];
        tpsf_pkg::RegInvIndLL:    ill_q   <= cfg_data_i;
        tpsf_pkg::RegInvIndLG:    ilg_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state
  tpsf_pkg::seq_state_e st_q, st_d;
  logic [2:0]  mask_q, mask_d, cmd_q, cmd_d;
  logic signed [31:0] cur_q [3], cur_d [3];
  logic signed [31:0] prv_q [3], prv_d [3];
  logic signed [31:0] gfl_q [3], gfl_d [3];
  logic signed [31:0] pfl_q [3], pfl_d [3];
  logic signed [31:0] v_q [3], v_d [3];
  logic signed [31:0] src_q [3], src_d [3];
  logic [1:0]  ph_q, ph_d;
  logic        busy_q, busy_d;
  tpsf_pkg::fault_out_t out_q, out_d;

  tpsf_pkg::mul_req_t  mreq;
  logic signed [63:0]  prod;

  tpsf_mul u_mul (.clk_i(clk_i), .req_i(mreq), .prod_o(prod));

  // per-phase / per-pair operand selection
  logic pair_mode;
  logic [1:0] pidx, p2;
  logic signed [31:0] resv, curv, invl;
  logic signed [63:0] vdiff, flx;
  logic signed [63:0] newflx, newcur;

  assign pair_mode = ll_q;

  always_comb begin
    p2 = tpsf_pkg::PhB;
    pidx = ph_q;
    if (pair_mode) begin
      case (ph_q)
        2'd0: begin pidx = tpsf_pkg::PhA; p2 = tpsf_pkg::PhB; end
        2'd1: begin pidx = tpsf_pkg::PhB; p2 = tpsf_pkg::PhC; end
        default: begin pidx = tpsf_pkg::PhA; p2 = tpsf_pkg::PhC; end
      endcase
      vdiff = 64'(v_q[pidx]) - 64'(v_q[p2]);
      resv  = {1'b0, rll_q};
      flx   = 64'(pfl_q[ph_q]);
      invl  = ill_q;
    end else begin
      vdiff = 64'(v_q[ph_q]);
      resv  = {1'b0, rlg_q};
      flx   = 64'(gfl_q[ph_q]);
      invl  = ilg_q;
    end
    curv   = cur_q[pidx];
    newflx = sat(flx + prod);
    newcur = sat(prod);
  end

  // which pair/phase is active for integration
  logic [2:0] act;
  always_comb begin
    act = 3'b000;
    if (ll_q) begin
      if (mask_q[0] && mask_q[1]) act = 3'b001;
      else if (mask_q[1] && mask_q[2]) act = 3'b010;
      else if (mask_q[0] && mask_q[2]) act = 3'b100;
    end else begin
      act = mask_q;
    end
  end

  logic [2:0] rel;
  logic signed [31:0] mag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = cur_q[i][31] ? -cur_q[i] : cur_q[i];
      rel[i] = ({1'b0, mag[i]} < {2'b00, thr_q}) ||
               (cur_q[i][31] && prv_q[i] > 0) ||
               (cur_q[i] > 0 && prv_q[i][31]);
    end
  end

  logic signed [32:0] avg;

  always_comb begin
    st_d = st_q; mask_d = mask_q; cmd_d = cmd_q; ph_d = ph_q; busy_d = busy_q;
    cur_d = cur_q; prv_d = prv_q; gfl_d = gfl_q; pfl_d = pfl_q;
    v_d = v_q; src_d = src_q; out_d = out_q;
    mreq = '{start: 1'b0, op_a: 32'sd0, op_b: 32'sd0};
    avg = '0;
    in_if.ready = (st_q == tpsf_pkg::StIdle);
    if (busy_q && out_if.ready) busy_d = 1'b0;
    case (st_q)
      tpsf_pkg::StIdle: begin
        if (in_if.valid && in_if.ready) begin
          cmd_d = in_if.data.fault_enable ? in_if.data.fault_command : 3'b000;
          v_d[0] = in_if.data.va_fault_in; v_d[1] = in_if.data.vb_fault_in;
          v_d[2] = in_if.data.vc_fault_in;
          src_d[0] = in_if.data.va_source; src_d[1] = in_if.data.vb_source;
          src_d[2] = in_if.data.vc_source;
          st_d = tpsf_pkg::StMask;
        end
      end
      tpsf_pkg::StMask: begin
        for (int i = 0; i < 3; i++) begin
          mask_d[i] = (mask_q[i] | cmd_q[i]) && !(mask_q[i] && !cmd_q[i] && rel[i]);
        end
        prv_d = cur_q;
        ph_d = 2'd0;
        st_d = dmode_q ? tpsf_pkg::StDone : tpsf_pkg::StNext;
        if (dmode_q) begin
          if (ll_q) begin
            if (mask_d[0] && mask_d[1]) begin
              avg = 33'(src_q[0]) + 33'(src_q[1]);
              v_d[0] = avg[32:1]; v_d[1] = avg[32:1];
            end else if (mask_d[0] && mask_d[2]) begin
              avg = 33'(src_q[0]) + 33'(src_q[2]);
              v_d[0] = avg[32:1]; v_d[2] = avg[32:1];
            end else if (mask_d[1] && mask_d[2]) begin
              avg = 33'(src_q[1]) + 33'(src_q[2]);
              v_d[1] = avg[32:1]; v_d[2] = avg[32:1];
            end
          end else begin
            for (int i = 0; i < 3; i++) if (mask_d[i]) v_d[i] = '0;
          end
        end
      end
      tpsf_pkg::StNext: begin
        if (ph_q == 2'd3) st_d = tpsf_pkg::StDone;
        else if (act[ph_q]) begin
          mreq = '{start: 1'b1, op_a: resv, op_b: curv};
          st_d = tpsf_pkg::StResMul;
        end else ph_d = ph_q + 2'd1;
      end
      tpsf_pkg::StResMul: begin
        mreq = '{start: 1'b1, op_a: {1'b0, dt_q}, op_b: 32'(sat(vdiff - prod))};
        st_d = tpsf_pkg::StDtMul;
      end
      tpsf_pkg::StDtMul: begin
        if (pair_mode) pfl_d[ph_q] = 32'(newflx);
        else gfl_d[ph_q] = 32'(newflx);
        mreq = '{start: 1'b1, op_a: 32'(newflx), op_b: invl};
        st_d = tpsf_pkg::StIndMul;
      end
      tpsf_pkg::StIndMul: begin
        cur_d[pidx] = 32'(newcur);
        if (pair_mode) cur_d[p2] = 32'(sat(-newcur));
        ph_d = ph_q + 2'd1;
        st_d = tpsf_pkg::StNext;
      end
      tpsf_pkg::StDone: begin
        for (int i = 0; i < 3; i++) begin
          if (!mask_q[i]) begin
            gfl_d[i] = '0; cur_d[i] = '0;
          end
        end
        if (!mask_q[0]) begin pfl_d[0] = '0; pfl_d[2] = '0; end
        if (!mask_q[1]) begin pfl_d[0] = '0; pfl_d[1] = '0; end
        if (!mask_q[2]) begin pfl_d[1] = '0; pfl_d[2] = '0; end
        if (!busy_q || out_if.ready) begin
          out_d.fault_mask = mask_q;
          out_d.va_out = v_q[0];
          out_d.vb_out = v_q[1];
          out_d.vc_out = v_q[2];
          out_d.ia_out = cur_d[0];
          out_d.ib_out = cur_d[1];
          out_d.ic_out = cur_d[2];
          busy_d = 1'b1;
          st_d = tpsf_pkg::StIdle;
        end
      end
      default: st_d = tpsf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tpsf_pkg::StIdle; mask_q <= '0; busy_q <= 1'b0; ph_q <= '0; cmd_q <= '0;
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= '0; prv_q[i] <= '0; gfl_q[i] <= '0; pfl_q[i] <= '0;
      end
    end else begin
      st_q <= st_d; mask_q <= mask_d; busy_q <= busy_d; ph_q <= ph_d; cmd_q <= cmd_d;
      cur_q <= cur_d; prv_q <= prv_d; gfl_q <= gfl_d; pfl_q <= pfl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; src_q <= src_d; out_q <= out_d;
  end

  assign out_if.valid = busy_q;
  assign out_if.data  = out_q;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result dropped or changed while waiting");
  a_done_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == tpsf_pkg::StDone |=> busy_q) else $error("result not raised");
  a_clear_unmasked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.data.fault_mask[0] |-> out_if.data.ia_out == 0)
    else $error("unfaulted current kept");
`endif
endmodule

FILE: rtl/core/tpsf_mul.sv
// shared signed multiplier with registered product and q16 shift
module tpsf_mul (
  input  logic                clk_i,
  input  tpsf_pkg::mul_req_t  req_i,
  output logic signed [63:0]  prod_o
);
  logic signed [63:0] prod_q;
  logic signed [63:0] prod_d;
  logic signed [63:0] full;

  assign full   = $signed(req_i.op_a) * $signed(req_i.op_b);
  assign prod_d = req_i.start ? (full >>> 16) : prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;
endmodule

FILE: tb/sv/tb.sv
// testbench for the three-phase short-circuit fault model: directed and random requests vs a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;
  localparam int StallLimit = 5000;

  class fault_scoreboard;
    bit direct, l2l;
    longint thresh, dt, r_ll, r_lg, g_ll, g_lg;
    logic [2:0] mask = 3'b000;
    longint cur[3], prev[3], gflux[3], pflux[3];
    tpsf_pkg::fault_out_t pending[$];
    int errors;

    function void set_reg(tpsf_pkg::cfg_reg_e idx, logic [31:0] val);
      case (idx)
        tpsf_pkg::RegDirectMode:  direct = val[0];
        tpsf_pkg::RegLineToLine:  l2l = val[0];
        tpsf_pkg::RegOpenThresh:  thresh = longint'({1'b0, val[30:0]});
        tpsf_pkg::RegTimeStep:    dt = longint'({1'b0, val[30:0]});
        tpsf_pkg::RegResLineLine: r_ll = longint'({1'b0, val[30:0]});
        tpsf_pkg::RegResLineGnd:  r_lg = longint'({1'b0, val[30:0]});
        tpsf_pkg::RegInvIndLL:    g_ll = longint'($signed(val));
        tpsf_pkg::RegInvIndLG:    g_lg = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function longint sat(longint x);
      if (x > WordMax) return WordMax;
      if (x < WordMin) return WordMin;
      return x;
    endfunction

    function longint mulq(longint a, longint b);
      return (a * b) >>> 16;
    endfunction

    function longint integ(longint flux, longint vdiff, longint res, longint i_now);
      longint term;
      term = sat(vdiff - mulq(res, i_now));
      return sat(flux + mulq(dt, term));
    endfunction

    function bit opens(longint now, longint was);
      longint mag;
      mag = now < 0 ? -now : now;
      if (mag < thresh) return 1;
      return (now < 0 && was > 0) || (now > 0 && was < 0);
    endfunction

    function void note_request(tpsf_pkg::fault_in_t r);
      logic [2:0] cmd;
      longint v[3], s[3];
      tpsf_pkg::fault_out_t e;
      cmd = r.fault_enable ? r.fault_command : 3'b000;
      v[0] = r.va_fault_in; v[1] = r.vb_fault_in; v[2] = r.vc_fault_in;
      s[0] = r.va_source; s[1] = r.vb_source; s[2] = r.vc_source;
      mask = mask | cmd;
      for (int i = 0; i < 3; i++)
        if (mask[i] && !cmd[i] && opens(cur[i], prev[i])) mask[i] = 1'b0;
      for (int i = 0; i < 3; i++) prev[i] = cur[i];
      if (direct) begin
        if (l2l) begin
          if (mask[0] && mask[1]) begin
            v[0] = (s[0] + s[1]) >>> 1; v[1] = v[0];
          end else if (mask[0] && mask[2]) begin
            v[0] = (s[0] + s[2]) >>> 1; v[2] = v[0];
          end else if (mask[1] && mask[2]) begin
            v[1] = (s[1] + s[2]) >>> 1; v[2] = v[1];
          end
        end else begin
          for (int i = 0; i < 3; i++) if (mask[i]) v[i] = 0;
        end
      end else if (l2l) begin
        if (mask[0] && mask[1]) begin
          pflux[0] = integ(pflux[0], v[0] - v[1], r_ll, cur[0]);
          cur[0] = sat(mulq(pflux[0], g_ll));
          cur[1] = sat(-cur[0]);
        end else if (mask[1] && mask[2]) begin
          pflux[1] = integ(pflux[1], v[1] - v[2], r_ll, cur[1]);
          cur[1] = sat(mulq(pflux[1], g_ll));
          cur[2] = sat(-cur[1]);
        end else if (mask[0] && mask[2]) begin
          pflux[2] = integ(pflux[2], v[0] - v[2], r_ll, cur[0]);
          cur[0] = sat(mulq(pflux[2], g_ll));
          cur[2] = sat(-cur[0]);
        end
      end else begin
        for (int i = 0; i < 3; i++)
          if (mask[i]) begin
            gflux[i] = integ(gflux[i], v[i], r_lg, cur[i]);
            cur[i] = sat(mulq(gflux[i], g_lg));
          end
      end
      if (!mask[0]) begin gflux[0] = 0; pflux[0] = 0; pflux[2] = 0; cur[0] = 0; end
      if (!mask[1]) begin gflux[1] = 0; pflux[0] = 0; pflux[1] = 0; cur[1] = 0; end
      if (!mask[2]) begin gflux[2] = 0; pflux[1] = 0; pflux[2] = 0; cur[2] = 0; end
      e.fault_mask = mask;
      e.va_out = v[0][31:0]; e.vb_out = v[1][31:0]; e.vc_out = v[2][31:0];
      e.ia_out = cur[0][31:0]; e.ib_out = cur[1][31:0]; e.ic_out = cur[2][31:0];
      pending.push_back(e);
    endfunction

    function void check_result(tpsf_pkg::fault_out_t got);
      tpsf_pkg::fault_out_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.fault_mask !== e.fault_mask) begin
        $error("fault_mask exp %0h got %0h", e.fault_mask, got.fault_mask); errors++;
      end
      if (got.va_out !== e.va_out) begin
        $error("va_out exp %0d got %0d", e.va_out, got.va_out); errors++;
      end
      if (got.vb_out !== e.vb_out) begin
        $error("vb_out exp %0d got %0d", e.vb_out, got.vb_out); errors++;
      end
      if (got.vc_out !== e.vc_out) begin
        $error("vc_out exp %0d got %0d", e.vc_out, got.vc_out); errors++;
      end
      if (got.ia_out !== e.ia_out) begin
        $error("ia_out exp %0d got %0d", e.ia_out, got.ia_out); errors++;
      end
      if (got.ib_out !== e.ib_out) begin
        $error("ib_out exp %0d got %0d", e.ib_out, got.ib_out); errors++;
      end
      if (got.ic_out !== e.ic_out) begin
        $error("ic_out exp %0d got %0d", e.ic_out, got.ic_out); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tpsf_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [tpsf_pkg::CfgDataW-1:0] cfg_data_i = '0;
  int idle_cycles = 0;
  bit ready_busy = 1'b0;

  tpsf_if #(.payload_t(tpsf_pkg::fault_in_t)) in_if ();
  tpsf_if #(.payload_t(tpsf_pkg::fault_out_t)) out_if ();

  fault_scoreboard fault_sb = new();

  three_phase_short_fault_model_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) fault_sb.note_request(in_if.data);
    if (out_if.valid && out_if.ready) fault_sb.check_result(out_if.data);
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result-side stalls: stretches of always ready and of random stalls
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) ready_busy <= ~ready_busy;
    if (!ready_busy) out_if.ready <= 1'b1;
    else if ($urandom_range(0, 29) == 0) out_if.ready <= 1'b0;
    else out_if.ready <= $urandom_range(0, 2) != 0;
  end

  task automatic write_reg(tpsf_pkg::cfg_reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fault_sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (fault_sb.pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic send_request(tpsf_pkg::fault_in_t r, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= r;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_volt();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h7ffff) - 32'h40000;
    endcase
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h7fffffff;
      2: return $urandom();
      default: return $urandom_range(0, 32'h30000);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h40000) - 32'h20000;
    endcase
  endfunction

  function automatic tpsf_pkg::fault_in_t make_request(logic en, logic [2:0] cmd);
    tpsf_pkg::fault_in_t r;
    r.fault_enable = en;
    r.fault_command = cmd;
    r.va_fault_in = pick_volt(); r.vb_fault_in = pick_volt(); r.vc_fault_in = pick_volt();
    r.va_source = pick_volt(); r.vb_source = pick_volt(); r.vc_source = pick_volt();
    return r;
  endfunction

  task automatic load_config(logic dm, logic ll);
    write_reg(tpsf_pkg::RegDirectMode, ($urandom() & 32'hfffffffe) | {31'd0, dm});
    write_reg(tpsf_pkg::RegLineToLine, ($urandom() & 32'hfffffffe) | {31'd0, ll});
    write_reg(tpsf_pkg::RegOpenThresh, pick_pos());
    write_reg(tpsf_pkg::RegTimeStep, pick_pos());
    write_reg(tpsf_pkg::RegResLineLine, pick_pos());
    write_reg(tpsf_pkg::RegResLineGnd, pick_pos());
    write_reg(tpsf_pkg::RegInvIndLL, pick_gain());
    write_reg(tpsf_pkg::RegInvIndLG, pick_gain());
  endtask

  initial begin
    tpsf_pkg::fault_in_t r;
    logic [2:0] cmd;
    int hold;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every command, release by threshold and by sign change
    write_reg(tpsf_pkg::RegTimeStep, 32'h7fffffff);
    write_reg(tpsf_pkg::RegInvIndLG, 32'h7fffffff);
    write_reg(tpsf_pkg::RegResLineGnd, 32'h0);
    write_reg(tpsf_pkg::RegOpenThresh, 32'h0);
    for (int c = 0; c < 8; c++) send_request(make_request(1'b1, c[2:0]), 0);
    r = make_request(1'b1, 3'b111);
    r.va_fault_in = 32'h7fffffff; r.vb_fault_in = 32'h80000000; r.vc_fault_in = 32'h1;
    send_request(r, 0);
    r.va_fault_in = 32'h80000000; r.vb_fault_in = 32'h7fffffff;
    send_request(r, 0);
    send_request(make_request(1'b0, 3'b111), 0);
    send_request(make_request(1'b0, 3'b000), 0);
    drain();
    write_reg(tpsf_pkg::RegDirectMode, 32'h1);
    write_reg(tpsf_pkg::RegLineToLine, 32'h1);
    write_reg(tpsf_pkg::RegInvIndLL, 32'h80000000);
    write_reg(tpsf_pkg::RegResLineLine, 32'h7fffffff);
    write_reg(tpsf_pkg::RegOpenThresh, 32'h7fffffff);
    for (int c = 3; c < 8; c++) begin
      r = make_request(1'b1, c[2:0]);
      r.va_source = 32'h7fffffff; r.vb_source = 32'h7fffffff; r.vc_source = 32'h80000000;
      send_request(r, 0);
    end
    send_request(make_request(1'b0, 3'b000), 0);
    drain();

    // random phases, each under its own setting
    for (int ph = 0; ph < 16; ph++) begin
      load_config(ph % 4 == 1 || ph % 4 == 3, ph % 4 >= 2);
      for (int n = 0; n < 64; ) begin
        cmd = 3'($urandom_range(0, 7));
        hold = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) begin
          send_request(make_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))),
                       pick_gap());
          n++;
        end else begin
          for (int k = 0; k < hold; k++) begin
            send_request(make_request(1'b1, cmd), pick_gap());
            n++;
          end
          hold = $urandom_range(1, 6);
          for (int k = 0; k < hold; k++) begin
            send_request(make_request(1'($urandom_range(0, 1)),
                                      cmd & 3'($urandom_range(0, 7))), pick_gap());
            n++;
          end
        end
      end
      drain();
    end

    if (fault_sb.errors == 0 && fault_sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
